### hw/rtl/pprq_pkg.sv
// ----------------------------------------------------------------------------
// pprq_pkg
// Types, sizes and codes shared by the process priority ready queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pprq_pkg;

    // Sizes
    localparam int DEPTH     = 16;
    localparam int PID_BITS  = 8;
    localparam int PRIO_BITS = 4;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int OCC_BITS  = 5;
    localparam int IDX_BITS  = $clog2(DEPTH);

    // Operation codes
    typedef enum logic [1:0] {
        OP_INS_AFTER  = 2'd0,
        OP_INS_BEFORE = 2'd1,
        OP_POP        = 2'd2,
        OP_REMOVE     = 2'd3
    } op_t;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // One queue entry
    typedef struct packed {
        logic [PID_BITS-1:0]  pid;
        logic [PRIO_BITS-1:0] prio;
    } entry_t;

    // Command transaction
    typedef struct packed {
        op_t                  op;
        logic [PID_BITS-1:0]  pid;
        logic [PRIO_BITS-1:0] priority_req;
    } cmd_t;

    // Result transaction
    typedef struct packed {
        status_t              status;
        logic [PID_BITS-1:0]  out_pid;
        logic [PRIO_BITS-1:0] out_priority;
        logic [OCC_BITS-1:0]  occupancy;
    } result_t;

    // Controls broadcast to every cell
    typedef struct packed {
        logic   ins_en;     // commit an insert this cycle
        logic   rem_en;     // commit a pop / remove this cycle
        logic   before_eq;  // insert ahead of equal priorities
        logic   pop_mode;   // match the head instead of a pid
        entry_t req;        // entry to insert, pid to look for
    } cell_ctrl_t;

endpackage : pprq_pkg

`default_nettype wire

### hw/rtl/pprq_cell.sv
// ----------------------------------------------------------------------------
// pprq_cell
// One slot of the sorted queue. Compares its entry against the broadcast
// request and shifts toward the tail on insert or toward the head on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module pprq_cell (
    input  wire                   clk,
    input  pprq_pkg::cell_ctrl_t  ctrl,
    input  wire                   valid,        // slot index below count
    input  wire                   is_head,
    input  wire                   left_flag,    // left neighbor stays in place
    input  pprq_pkg::entry_t      left_entry,
    input  pprq_pkg::entry_t      right_entry,
    input  wire                   found_in,     // match seen nearer the head
    input  pprq_pkg::entry_t      sel_in,
    output logic                  flag,
    output pprq_pkg::entry_t      entry,
    output logic                  found_out,
    output pprq_pkg::entry_t      sel_out
);

    pprq_pkg::entry_t entry_reg;
    pprq_pkg::entry_t entry_next;
    logic             match;
    logic             prio_lt;
    logic             prio_eq;

    // Local compares
    assign prio_lt = entry_reg.prio < ctrl.req.prio;
    assign prio_eq = entry_reg.prio == ctrl.req.prio;
    assign flag    = valid & (prio_lt | (prio_eq & ~ctrl.before_eq));
    assign match   = valid & (ctrl.pop_mode ? is_head : (entry_reg.pid == ctrl.req.pid));

    // First-match chain toward the tail
    assign found_out = found_in | match;
    assign sel_out   = found_in ? sel_in : entry_reg;
    assign entry     = entry_reg;

    // Slot update
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en && !flag)
        begin
            entry_next = left_flag ? ctrl.req : left_entry;
        end
        else if (ctrl.rem_en && found_out)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule : pprq_cell

`default_nettype wire

### hw/rtl/process_priority_ready_queue.sv
// ----------------------------------------------------------------------------
// process_priority_ready_queue
// Stable sorted ready queue of (pid, priority) entries held in a row of cells.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  command   start & !busy         cmd    (op, pid, priority_req)
//  result    done, one cycle       result (status, out_pid, out_priority,
//                                          occupancy)
//
//  Each command is first registered, then handled in the exec state, in which every
//  cell compares in parallel and the row shifts; the result strobes on the next
//  cycle while a new command may already be taken.
//  Reset clears the control state and the entry count; slot contents are
//  not reset. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module process_priority_ready_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    output logic                   busy,
    input  pprq_pkg::cmd_t         cmd,
    output logic                   done,
    output pprq_pkg::result_t      result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    pprq_pkg::cmd_t                 cmd_reg;
    logic [pprq_pkg::CNT_BITS-1:0]  count_reg;
    logic [pprq_pkg::CNT_BITS-1:0]  count_next;
    logic                           done_reg;
    pprq_pkg::result_t              result_reg;
    pprq_pkg::result_t              result_next;

    pprq_pkg::cell_ctrl_t           ctrl;
    logic                           is_ins;
    logic                           full;
    logic                           empty;
    logic                           exec;

    logic             [pprq_pkg::DEPTH-1:0] valid;
    logic             [pprq_pkg::DEPTH-1:0] flag;
    logic             [pprq_pkg::DEPTH:0]   found;
    pprq_pkg::entry_t [pprq_pkg::DEPTH-1:0] entry;
    pprq_pkg::entry_t [pprq_pkg::DEPTH:0]   sel;

    // Control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            count_reg <= count_next;
        end
    end

    assign busy = (state_reg == S_EXEC);
    assign exec = busy;

    // Command register
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
    end

    // Broadcast to the cells
    assign is_ins = (cmd_reg.op == pprq_pkg::OP_INS_AFTER) ||
                    (cmd_reg.op == pprq_pkg::OP_INS_BEFORE);
    assign full   = (count_reg >= pprq_pkg::CNT_BITS'(pprq_pkg::DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        ctrl.ins_en    = exec & is_ins & ~full;
        ctrl.rem_en    = exec & ~is_ins;
        ctrl.before_eq = (cmd_reg.op == pprq_pkg::OP_INS_BEFORE);
        ctrl.pop_mode  = (cmd_reg.op == pprq_pkg::OP_POP);
        ctrl.req.pid   = cmd_reg.pid;
        ctrl.req.prio  = cmd_reg.priority_req;
    end

    // Row of cells, head at index 0
    assign found[0] = 1'b0;
    assign sel[0]   = ctrl.req;

    for (genvar i = 0; i < pprq_pkg::DEPTH; i++)
    begin : g_cell
        assign valid[i] = pprq_pkg::CNT_BITS'(i) < count_reg;

        pprq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (valid[i]),
            .is_head     ((i == 0) ? 1'b1 : 1'b0),
            .left_flag   ((i == 0) ? 1'b1 : flag[(i == 0) ? 0 : i - 1]),
            .left_entry  (entry[(i == 0) ? 0 : i - 1]),
            .right_entry (entry[(i == pprq_pkg::DEPTH - 1) ? i : i + 1]),
            .found_in    (found[i]),
            .sel_in      (sel[i]),
            .flag        (flag[i]),
            .entry       (entry[i]),
            .found_out   (found[i+1]),
            .sel_out     (sel[i+1])
        );
    end

    // Count and result
    always_comb
    begin
        count_next               = count_reg;
        result_next.status       = pprq_pkg::ST_OK;
        result_next.out_pid      = '0;
        result_next.out_priority = '0;
        if (is_ins)
        begin
            if (full)
            begin
                result_next.status = pprq_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (empty)
        begin
            result_next.status = pprq_pkg::ST_EMPTY;
        end
        else if (!found[pprq_pkg::DEPTH])
        begin
            result_next.status = pprq_pkg::ST_NOT_FOUND;
        end
        else
        begin
            count_next               = count_reg - 1'b1;
            result_next.out_pid      = sel[pprq_pkg::DEPTH].pid;
            result_next.out_priority = sel[pprq_pkg::DEPTH].prio;
        end
        if (!exec)
        begin
            count_next = count_reg;
        end
        result_next.occupancy = pprq_pkg::OCC_BITS'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule : process_priority_ready_queue

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for process_priority_ready_queue.
// A directed run walks the queue through empty, matching, not found and full.
// A longer random run then cycles through insert-heavy, balanced and drain-heavy phases.
// Every accepted command is applied to a local sorted list that predicts the
// result. Each strobed result is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------

module testbench;

    localparam int RANDOM_ITEMS = 800;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 6;

    // Prediction waiting for its result, stamped with the acceptance cycle
    typedef struct {
        pprq_pkg::result_t res;
        longint            stamp;
    } forecast_t;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    pprq_pkg::cmd_t    cmd   = '0;
    logic              busy;
    logic              done;
    pprq_pkg::result_t result;

    pprq_pkg::cmd_t    cmd_queue[$];
    forecast_t         due_results[$];

    // Local copy of the ready list, head at index 0
    pprq_pkg::entry_t ready_list[pprq_pkg::DEPTH];
    int               fill_level = 0;

    longint cycle_no    = 0;
    int     idle_cycles = 0;
    int     n_issued    = 0;
    int     n_total     = 0;
    int     errors      = 0;
    int     burst_left  = 8;
    int     gap_left    = 0;
    pprq_pkg::result_t got_r;
    pprq_pkg::result_t want_r;

    process_priority_ready_queue DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one command to the local list and return the result it should give
    function automatic pprq_pkg::result_t apply_command(pprq_pkg::cmd_t c);
        pprq_pkg::result_t r;
        int                pos;
        int                i;
        r        = '0;
        r.status = pprq_pkg::ST_OK;
        if (c.op == pprq_pkg::OP_INS_AFTER || c.op == pprq_pkg::OP_INS_BEFORE)
        begin
            if (fill_level >= pprq_pkg::DEPTH)
                r.status = pprq_pkg::ST_FULL;
            else
            begin
                pos = 0;
                while (pos < fill_level &&
                       ((c.op == pprq_pkg::OP_INS_AFTER)
                            ? ready_list[pos].prio <= c.priority_req
                            : ready_list[pos].prio < c.priority_req))
                    pos++;
                for (i = fill_level; i > pos; i--)
                    ready_list[i] = ready_list[i-1];
                ready_list[pos].pid  = c.pid;
                ready_list[pos].prio = c.priority_req;
                fill_level++;
            end
        end
        else if (fill_level == 0)
            r.status = pprq_pkg::ST_EMPTY;
        else
        begin
            // Pop takes the head, remove takes the first pid match
            pos = 0;
            if (c.op == pprq_pkg::OP_REMOVE)
                while (pos < fill_level && ready_list[pos].pid != c.pid)
                    pos++;
            if (pos >= fill_level)
                r.status = pprq_pkg::ST_NOT_FOUND;
            else
            begin
                r.out_pid      = ready_list[pos].pid;
                r.out_priority = ready_list[pos].prio;
                for (i = pos; i + 1 < fill_level; i++)
                    ready_list[i] = ready_list[i+1];
                fill_level--;
            end
        end
        r.occupancy = pprq_pkg::OCC_BITS'(fill_level);
        return r;
    endfunction

    function automatic void add_cmd(pprq_pkg::op_t op,
                                    logic [pprq_pkg::PID_BITS-1:0] pid,
                                    logic [pprq_pkg::PRIO_BITS-1:0] prio);
        pprq_pkg::cmd_t c;
        c.op           = op;
        c.pid          = pid;
        c.priority_req = prio;
        cmd_queue.push_back(c);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Cycle counter and idle watch
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Driver: bursts of commands with random gaps, held while busy
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                due_results.push_back('{apply_command(cmd), cycle_no});
                n_issued++;
            end
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (cmd_queue.size() > 0)
            begin
                start <= 1'b1;
                cmd   <= cmd_queue.pop_front();
                if (burst_left <= 1)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(20, 60);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 10);
                        gap_left   = $urandom_range(1, 8);
                    end
                end
                else
                    burst_left--;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check each strobed result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got_r = result;
            if (due_results.size() == 0 || due_results[0].stamp >= cycle_no)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got_r);
                errors++;
            end
            else
            begin
                want_r = due_results.pop_front().res;
                check_field("status", want_r.status, got_r.status);
                check_field("out_pid", want_r.out_pid, got_r.out_pid);
                check_field("out_priority", want_r.out_priority, got_r.out_priority);
                check_field("occupancy", want_r.occupancy, got_r.occupancy);
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int                             k;
        int                             ins_pct;
        int                             chunk;
        int                             roll;
        logic [pprq_pkg::PID_BITS-1:0]  pid_pool[10];
        logic [pprq_pkg::PID_BITS-1:0]  p;
        logic [pprq_pkg::PRIO_BITS-1:0] q;

        // Empty list, extremes, equal priorities, miss and hit
        add_cmd(pprq_pkg::OP_POP, 8'hFF, 4'hF);
        add_cmd(pprq_pkg::OP_REMOVE, 8'h00, 4'h0);
        add_cmd(pprq_pkg::OP_INS_AFTER, 8'h00, 4'h0);
        add_cmd(pprq_pkg::OP_INS_AFTER, 8'hFF, 4'hF);
        add_cmd(pprq_pkg::OP_INS_BEFORE, 8'hAA, 4'hF);
        add_cmd(pprq_pkg::OP_INS_AFTER, 8'h55, 4'h0);
        add_cmd(pprq_pkg::OP_REMOVE, 8'h77, 4'h3);
        add_cmd(pprq_pkg::OP_REMOVE, 8'hFF, 4'h0);
        // Fill to capacity, with duplicate pids
        for (k = 0; k < 13; k++)
            add_cmd((k % 2) ? pprq_pkg::OP_INS_BEFORE : pprq_pkg::OP_INS_AFTER,
                    (k % 4 == 0) ? 8'h55 : pprq_pkg::PID_BITS'(8'h10 + k),
                    pprq_pkg::PRIO_BITS'((k * 5) % 16));
        // Full list, then drain a little
        add_cmd(pprq_pkg::OP_INS_AFTER, 8'h33, 4'h7);
        add_cmd(pprq_pkg::OP_INS_BEFORE, 8'hCC, 4'h0);
        add_cmd(pprq_pkg::OP_POP, 8'h00, 4'h0);
        add_cmd(pprq_pkg::OP_REMOVE, 8'h55, 4'hF);

        // Random phases: insert heavy, balanced, drain heavy
        for (k = 0; k < 10; k++)
            pid_pool[k] = pprq_pkg::PID_BITS'($urandom_range(0, 255));
        chunk = 0;
        while (chunk < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0: ins_pct = 85;
                1: ins_pct = 50;
                default: ins_pct = 20;
            endcase
            for (k = $urandom_range(10, 40); k > 0; k--)
            begin
                roll = $urandom_range(0, 99);
                p    = ($urandom_range(0, 4) == 0)
                           ? pprq_pkg::PID_BITS'($urandom_range(0, 255))
                           : pid_pool[$urandom_range(0, 9)];
                q    = ($urandom_range(0, 1) == 0)
                           ? pprq_pkg::PRIO_BITS'($urandom_range(0, 15))
                           : pprq_pkg::PRIO_BITS'($urandom_range(6, 8));
                if (roll < ins_pct)
                    add_cmd($urandom_range(0, 1) ? pprq_pkg::OP_INS_BEFORE
                                                 : pprq_pkg::OP_INS_AFTER, p, q);
                else
                    add_cmd($urandom_range(0, 1) ? pprq_pkg::OP_REMOVE
                                                 : pprq_pkg::OP_POP, p, q);
                chunk++;
            end
        end
        n_total = cmd_queue.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (n_issued < n_total || due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: too long with nothing accepted
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/pprq_pkg.sv
hw/rtl/pprq_cell.sv
hw/rtl/process_priority_ready_queue.sv
test/testbench.sv
